// ----- rtl/skvt_pkg.sv -----
// Package for the sorted key/value table.
// Holds the table size, derived widths, operation codes and the cell control struct.
// No dependencies.
package skvt_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int OP_W     = 2;
	localparam int POS_W    = 6;
	localparam int GRP_SIZE = 8;
	localparam int GROUPS   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	localparam logic [OP_W-1:0] OP_SET     = 2'd0;
	localparam logic [OP_W-1:0] OP_GET_KEY = 2'd1;
	localparam logic [OP_W-1:0] OP_GET_IDX = 2'd2;
	localparam logic [OP_W-1:0] OP_HAS     = 2'd3;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic cmp_en;  // capture the compare flags against the search key
		logic upd_en;  // apply the update decided from the captured flags
		logic set_op;  // the transaction is a set
		logic insert;  // a new key goes in: the row shifts up from the insert point
	} cell_ctl_t;

endpackage

// ----- rtl/skvt_cell.sv -----
// One entry of the sorted key/value row.
// Depends on skvt_pkg; takes shifted data from the cell below it.
module skvt_cell
	import skvt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic                    occ,
	input  logic signed [KEY_W-1:0] search_key,
	input  logic        [VAL_W-1:0] new_value,
	input  logic                    lt_prev,
	input  logic signed [KEY_W-1:0] prev_key,
	input  logic        [VAL_W-1:0] prev_value,
	output logic signed [KEY_W-1:0] key_q,
	output logic        [VAL_W-1:0] value_q,
	output logic                    lt_q,
	output logic                    eq_q
);

	// Compare flags; an empty cell is never below nor equal to the key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			lt_q <= occ && (key_q < search_key);
			eq_q <= occ && (key_q == search_key);
		end
	end

	// Set hit: the equal cell takes the new value. Insert: the first cell not
	// below the key takes the new pair, those above shift up. Others keep theirs.
	always_ff @(posedge clk) begin
		if (ctl.upd_en) begin
			priority if (ctl.set_op && eq_q) begin
				value_q <= new_value;
			end else if (ctl.insert && !lt_q) begin
				if (lt_prev) begin
					key_q   <= search_key;
					value_q <= new_value;
				end else begin
					key_q   <= prev_key;
					value_q <= prev_value;
				end
			end else begin
				key_q   <= key_q;
				value_q <= value_q;
			end
		end
	end

endmodule

// ----- rtl/sorted_key_value_table.sv -----
// Sorted key/value table: a row of CAPACITY cells, each holding one key/value pair.
// A transaction passes the compare and update states and its result goes to the output
// register. One transaction at a time: in_stall stays high through the compare/update pass
// over the cell row until the result leaves for the output register, and longer while
// the receiver stalls a waiting result.
// Reset (arst_n, asynchronous): entry count and control go to zero; cell contents are
// left undefined and only occupied cells take part in any compare or read.
module sorted_key_value_table
	import skvt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic        [OP_W-1:0]  op,
	input  logic signed [KEY_W-1:0] key,
	input  logic        [VAL_W-1:0] value,
	input  logic        [POS_W-1:0] position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    found,
	output logic        [VAL_W-1:0] read_value,
	output logic                    status,
	output logic        [CNT_W-1:0] entry_count
);

	// Sequencer: IDLE takes a transaction, CMP lets every cell compare its key,
	// ACT applies the update and reduces the read data per group, DONE loads the
	// output register as soon as it is free.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_ACT  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]              state_q;
	logic [OP_W-1:0]         op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [VAL_W-1:0]        value_q;
	logic [POS_W-1:0]        pos_q;
	logic [CNT_W-1:0]        count_q;

	logic                    in_accept;
	logic                    out_free;
	cell_ctl_t               ctl;
	logic [CAPACITY-1:0]     occ;
	logic [CAPACITY-1:0]     lt_w;
	logic [CAPACITY-1:0]     eq_w;
	logic [CAPACITY-1:0]     sel;
	logic signed [KEY_W-1:0] cell_key   [CAPACITY];
	logic [VAL_W-1:0]        cell_value [CAPACITY];

	logic                    hit;
	logic                    full;
	logic                    idx_ok;

	// Results of the update cycle, waiting for the output register.
	logic [VAL_W-1:0]        grp_s2 [GROUPS];
	logic                    found_s2;
	logic                    status_s2;
	logic                    rd_en_s2;
	logic [VAL_W-1:0]        grp_or;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	// Global decisions: the hit from the compare flags captured in CMP, full and idx_ok from the count.
	assign hit    = |eq_w;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign idx_ok = ({1'b0, pos_q} < {{(CNT_W - POS_W){1'b0}}, count_q[POS_W-1:0]})
	                || (count_q > CNT_W'((1 << POS_W) - 1));

	always_comb begin
		ctl.cmp_en = (state_q == ST_CMP);
		ctl.upd_en = (state_q == ST_ACT);
		ctl.set_op = (op_q == OP_SET);
		ctl.insert = (op_q == OP_SET) && !hit && !full;
	end

	// The row of cells. Cell 0 sees "everything below is less" so that it takes
	// the new pair when it is the insert point.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    lt_prev;
		logic signed [KEY_W-1:0] prev_key;
		logic [VAL_W-1:0]        prev_value;

		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign lt_prev    = 1'b1;
			assign prev_key   = key_q;
			assign prev_value = value_q;
		end else begin : g_next
			assign lt_prev    = lt_w[i-1];
			assign prev_key   = cell_key[i-1];
			assign prev_value = cell_value[i-1];
		end

		// A cell drives the read data on a key hit, or when get by index points at it.
		assign sel[i] = ((op_q == OP_GET_KEY) && eq_w[i])
		             || ((op_q == OP_GET_IDX) && occ[i] && (CNT_W'(pos_q) == CNT_W'(i)));

		skvt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.occ        (occ[i]),
			.search_key (key_q),
			.new_value  (value_q),
			.lt_prev    (lt_prev),
			.prev_key   (prev_key),
			.prev_value (prev_value),
			.key_q      (cell_key[i]),
			.value_q    (cell_value[i]),
			.lt_q       (lt_w[i]),
			.eq_q       (eq_w[i])
		);
	end

	// Sequencer, transaction capture and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_ACT;
				end
				ST_ACT: begin
					state_q <= ST_DONE;
					if (ctl.insert) count_q <= count_q + CNT_W'(1);
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q    <= op;
			key_q   <= key;
			value_q <= value;
			pos_q   <= position;
		end
	end

	// First level of the read tree: one OR per group of cells, registered.
	always_ff @(posedge clk) begin
		if (state_q == ST_ACT) begin
			for (int g = 0; g < GROUPS; g++) begin
				logic [VAL_W-1:0] acc;
				acc = '0;
				for (int j = 0; j < GRP_SIZE; j++) begin
					if (g * GRP_SIZE + j < CAPACITY) begin
						if (sel[g * GRP_SIZE + j]) acc = acc | cell_value[g * GRP_SIZE + j];
					end
				end
				grp_s2[g] <= acc;
			end
			unique case (op_q)
				OP_SET:     found_s2 <= hit;
				OP_GET_KEY: found_s2 <= hit;
				OP_GET_IDX: found_s2 <= idx_ok;
				OP_HAS:     found_s2 <= hit;
				default:    found_s2 <= 1'b0;
			endcase
			status_s2 <= (op_q == OP_SET) && !hit && full;
			rd_en_s2  <= (op_q == OP_GET_KEY) || (op_q == OP_GET_IDX);
		end
	end

	// Second level of the read tree.
	always_comb begin
		grp_or = '0;
		for (int g = 0; g < GROUPS; g++) begin
			grp_or = grp_or | grp_s2[g];
		end
	end

	// Output register: holds a result while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= (state_q == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && (state_q == ST_DONE)) begin
			found       <= found_s2;
			read_value  <= rd_en_s2 ? grp_or : '0;
			status      <= status_s2;
			entry_count <= count_q;
		end
	end

endmodule

// ----- rtl/skvt_chk.sv -----
// Port-level checker for the sorted key/value table, bound to the top level.
// Depends on skvt_pkg and on the ports of sorted_key_value_table.
module skvt_chk
	import skvt_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic                    found,
	input logic        [VAL_W-1:0] read_value,
	input logic                    status,
	input logic        [CNT_W-1:0] entry_count
);

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(entry_count))
		else $error("result changed while stalled");

	// One transaction at a time: the block is busy right after taking one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in flight");

	// The entry count never exceeds the table size.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// A dropped insert only happens on a full table and finds nothing.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !found && read_value == '0 && entry_count == CNT_W'(CAPACITY))
		else $error("dropped insert with inconsistent result");

	// Read data only accompanies a hit.
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_value != '0) |-> found)
		else $error("read data without a hit");

endmodule

bind sorted_key_value_table skvt_chk u_skvt_chk (.*);

// ----- test/tb_sorted_key_value_table.sv -----
// Self-checking testbench for the sorted key/value table (sorted_key_value_table).
// Drives set, get, get-by-index and has transactions and checks every result against
// a cycle-free predictor of the table. Depends on skvt_pkg and the table RTL only.
module tb_sorted_key_value_table;
	import skvt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The run is bounded by a cycle counter. The slowest correct run needs roughly
	// 1200 transactions with long sender gaps and long receiver stalls, which
	// CYCLE_LIMIT covers with a wide margin.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_LIMIT = 10;
	localparam int POOL_SIZE    = 96;
	localparam int DRAIN_CYCLES = 12;

	// Result fields of one transaction, as the block reports them.
	typedef struct {
		logic             found;
		logic [VAL_W-1:0] read_value;
		logic             status;
		logic [CNT_W-1:0] entry_count;
	} table_reply_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic        [OP_W-1:0]  op;
	logic signed [KEY_W-1:0] key;
	logic        [VAL_W-1:0] value;
	logic        [POS_W-1:0] position;
	logic                    out_valid;
	logic                    out_stall;
	logic                    found;
	logic        [VAL_W-1:0] read_value;
	logic                    status;
	logic        [CNT_W-1:0] entry_count;

	// Predicted table contents. Only entries below table_count are meaningful,
	// exactly as in the block.
	logic signed [KEY_W-1:0] model_keys [CAPACITY];
	logic        [VAL_W-1:0] model_vals [CAPACITY];
	int                      table_count;

	// Expected results in transaction order, oldest first.
	table_reply_t pending_replies [$];

	// Keys for the random traffic. A pool larger than the table makes repeated
	// keys common (hits, overwrites) and still lets the table fill up and then
	// reject new keys.
	logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatch_count;
	int cycle_count;

	sorted_key_value_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.key         (key),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

	always #1 clk = ~clk;

	// Applies one operation to the predicted table and returns the result the
	// block must report for it. Keys are compared as signed 32-bit numbers.
	function automatic table_reply_t apply_table_op(input logic [OP_W-1:0] o,
			input logic signed [KEY_W-1:0] k, input logic [VAL_W-1:0] v,
			input logic [POS_W-1:0] p);
		table_reply_t r;
		int           slot;
		logic         hit;
		r.found      = 1'b0;
		r.read_value = '0;
		r.status     = 1'b0;
		// Lower bound: first occupied slot whose key is not below k.
		slot = 0;
		while (slot < table_count && model_keys[slot] < k)
			slot++;
		hit = (slot < table_count) && (model_keys[slot] == k);
		case (o)
			OP_SET: begin
				if (hit) begin
					model_vals[slot] = v;
					r.found = 1'b1;
				end else if (table_count >= CAPACITY) begin
					// New key on a full table: dropped and flagged.
					r.status = 1'b1;
				end else begin
					for (int j = table_count; j > slot; j--) begin
						model_keys[j] = model_keys[j-1];
						model_vals[j] = model_vals[j-1];
					end
					model_keys[slot] = k;
					model_vals[slot] = v;
					table_count++;
				end
			end
			OP_GET_KEY: begin
				if (hit) begin
					r.found      = 1'b1;
					r.read_value = model_vals[slot];
				end
			end
			OP_GET_IDX: begin
				// Positions at or above the count read as absent.
				if (int'(p) < table_count) begin
					r.found      = 1'b1;
					r.read_value = model_vals[p];
				end
			end
			default: begin
				r.found = hit;
			end
		endcase
		r.entry_count = CNT_W'(table_count);
		return r;
	endfunction

	// Sends one transaction. The sender may idle first; once valid is raised the
	// payload is held until the block takes it. Acceptance is decided from the
	// stall value sampled at the falling edge, which is stable up to the next
	// rising edge, so no race with the block's own updates is possible.
	task automatic send_op(input logic [OP_W-1:0] o, input logic signed [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v, input logic [POS_W-1:0] p);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		key      <= k;
		value    <= v;
		position <= p;
		pending_replies.push_back(apply_table_op(o, k, v, p));
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Empty table: every lookup misses and every index is out of range.
	task automatic test_empty_table();
		send_op(OP_GET_IDX, 32'sd0, 32'h0, 6'd0);
		send_op(OP_GET_KEY, 32'sd0, 32'hffff_ffff, 6'd0);
		send_op(OP_HAS, 32'sh8000_0000, 32'h0, 6'h3f);
		send_op(OP_GET_IDX, 32'sh7fff_ffff, 32'h0, 6'h3f);
	endtask

	// Inserts at the end, the front and the middle, with both key extremes,
	// so that the signed ordering and the shift on insert are both exercised.
	task automatic test_insert_order();
		send_op(OP_SET, 32'sd0, 32'h0000_0000, 6'd0);
		send_op(OP_SET, 32'sh7fff_ffff, 32'hffff_ffff, 6'd0);
		send_op(OP_SET, 32'sh8000_0000, 32'ha5a5_a5a5, 6'd0);
		send_op(OP_SET, -32'sd1, 32'h0000_0001, 6'd0);
		send_op(OP_SET, 32'sd1, 32'h5a5a_5a5a, 6'd0);
	endtask

	// Overwrite of an existing key, then hits and misses by key.
	task automatic test_overwrite_and_lookup();
		send_op(OP_SET, -32'sd1, 32'hdead_beef, 6'd0);
		send_op(OP_GET_KEY, -32'sd1, 32'h0, 6'd0);
		send_op(OP_HAS, 32'sd1, 32'h0, 6'd0);
		send_op(OP_HAS, 32'sd2, 32'h0, 6'd0);
		send_op(OP_GET_KEY, 32'sd2, 32'h0, 6'd0);
	endtask

	// Reads by position, including the first position at the count and the top one.
	task automatic test_index_reads();
		for (int i = 0; i <= 5; i++)
			send_op(OP_GET_IDX, 32'sd0, 32'h0, POS_W'(i));
		send_op(OP_GET_IDX, 32'sd0, 32'h0, 6'h3f);
	endtask

	// Random transactions with keys mostly drawn from the pool and now and then
	// fully random. Fields that an operation ignores carry random noise.
	task automatic test_random_traffic(input int items);
		logic [OP_W-1:0]         o;
		logic signed [KEY_W-1:0] k;
		int                      sel;
		for (int n = 0; n < items; n++) begin
			sel = $urandom_range(99);
			if (sel < 40)
				o = OP_SET;
			else if (sel < 65)
				o = OP_GET_KEY;
			else if (sel < 85)
				o = OP_GET_IDX;
			else
				o = OP_HAS;
			if ($urandom_range(9) < 8)
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				k = $urandom;
			send_op(o, k, $urandom, POS_W'($urandom_range(63)));
		end
	endtask

	// Fills the table if the random traffic has not, then checks that a new key
	// is dropped while an existing key can still be overwritten.
	task automatic test_full_table();
		while (table_count < CAPACITY)
			send_op(OP_SET, $urandom, $urandom, POS_W'($urandom_range(63)));
		send_op(OP_SET, $urandom, 32'h1234_5678, 6'd0);
		send_op(OP_SET, model_keys[0], 32'hffff_ffff, 6'd0);
		send_op(OP_GET_KEY, model_keys[0], 32'h0, 6'd0);
		send_op(OP_GET_IDX, 32'sd0, 32'h0, 6'h3f);
		send_op(OP_HAS, model_keys[CAPACITY-1], 32'h0, 6'd0);
	endtask

	// The receiver raises its stall at random; the rate changes per phase.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// A result is taken at a rising edge with valid high and stall low; both are
	// sampled at the falling edge before it, where they no longer change.
	always @(negedge clk) begin : reply_check
		table_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("Unexpected result: found %0b read_value %h status %0b count %0d",
						found, read_value, status, entry_count);
			end else begin
				want = pending_replies.pop_front();
				if (found !== want.found || read_value !== want.read_value ||
						status !== want.status || entry_count !== want.entry_count) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"Mismatch: expected found %0b read_value %h status %0b",
							" count %0d, got found %0b read_value %h status %0b count %0d"},
							want.found, want.read_value, want.status, want.entry_count,
							found, read_value, status, entry_count);
				end
			end
		end
	end

	// Guards against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		op             = OP_SET;
		key            = '0;
		value          = '0;
		position       = '0;
		out_stall      = 1'b0;
		table_count    = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		// Key pool: both extremes, zero and minus one, a dense cluster around zero
		// so that neighbors and near misses are frequent, and scattered random keys.
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < POOL_SIZE; i++) begin
			if (i < 40)
				key_pool[i] = int'($urandom_range(200)) - 100;
			else
				key_pool[i] = $urandom;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender mostly busy, receiver stalling about half the time.
		send_idle_pct  = 6;
		recv_stall_pct = 49;
		test_empty_table();
		test_insert_order();
		test_overwrite_and_lookup();
		test_index_reads();
		test_random_traffic(400);

		// Sender idling about half the time, receiver mostly ready.
		send_idle_pct  = 49;
		recv_stall_pct = 6;
		test_random_traffic(400);

		// Back-to-back traffic with no idling on either side.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_traffic(350);
		test_full_table();

		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		// Keep clocking after the last result so that a stray extra result would still be caught.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
